// ----- design/sflp_pkg.sv -----
// ----------------------------------------------------------------------------
// sflp_pkg: shared types and constants for the serial frame and line parser
// Frame modes, queue command codes, result kinds, header bytes and the
// damage lookup used to decode shot frames.
// ----------------------------------------------------------------------------
package sflp_pkg;

    // Frame tracking mode of the front end
    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_SHOT = 2'd1,
        MODE_MSG  = 2'd2
    } mode_t;

    // Commands passed from front end to back end
    typedef enum logic [1:0] {
        CMD_STORE    = 2'd0,  // store one line byte
        CMD_LINE_END = 2'd1,  // store the carriage return, then play the line out
        CMD_SHOT     = 2'd2,  // decode and emit a shot
        CMD_MSG      = 2'd3   // emit a message
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] byte_a;   // second frame byte
        logic [7:0] byte_b;   // third frame byte
        logic [7:0] byte_c;   // current byte
    } cmd_t;

    localparam int CmdWidth = $bits(cmd_t);

    // Result kind codes
    localparam logic [1:0] KIND_SHOT = 2'd0;
    localparam logic [1:0] KIND_MSG  = 2'd1;
    localparam logic [1:0] KIND_TEXT = 2'd2;

    // Special bytes
    localparam logic [7:0] HDR_SHOT   = 8'h0E;
    localparam logic [7:0] HDR_MSG    = 8'h18;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] SHOT_LIMIT = 8'd64;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] shot_damage;
        logic [1:0] shot_team;
        logic [6:0] shot_player;
        logic [7:0] message_id;
        logic [7:0] message_param;
        logic [7:0] message_control;
        logic [7:0] text_byte;
        logic       last;
    } result_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_EMIT = 2'd2
    } back_state_t;

    // Damage lookup, indexed by the low nibble of the shot data byte
    function automatic logic [6:0] damage_lookup(input logic [3:0] idx);
        logic [6:0] dmg;
        case (idx)
            4'd0:    dmg = 7'd1;
            4'd1:    dmg = 7'd2;
            4'd2:    dmg = 7'd4;
            4'd3:    dmg = 7'd5;
            4'd4:    dmg = 7'd7;
            4'd5:    dmg = 7'd10;
            4'd6:    dmg = 7'd15;
            4'd7:    dmg = 7'd17;
            4'd8:    dmg = 7'd20;
            4'd9:    dmg = 7'd25;
            4'd10:   dmg = 7'd30;
            4'd11:   dmg = 7'd35;
            4'd12:   dmg = 7'd40;
            4'd13:   dmg = 7'd50;
            4'd14:   dmg = 7'd75;
            default: dmg = 7'd100;
        endcase
        return dmg;
    endfunction

endpackage

// ----- design/sflp_front.sv -----
// ----------------------------------------------------------------------------
// sflp_front: byte classifier
// Tracks frame and line position for each received byte and issues store,
// line-end, shot and message commands into the queue.
// ----------------------------------------------------------------------------
module sflp_front #(
    parameter int LINE_BUFFER_DEPTH = 64,
    parameter int AW                = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_rx_byte,
    output logic                 cmd_valid,
    output sflp_pkg::cmd_t       cmd,
    output logic [AW-1:0]        cmd_addr,
    input  logic                 cmd_ready
);

    sflp_pkg::mode_t mode_reg, mode_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic [7:0]      one_reg, one_next;
    logic [7:0]      two_reg, two_next;
    logic            accept;

    assign s_ready = cmd_ready;
    assign accept  = s_valid && s_ready;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= sflp_pkg::MODE_TEXT;
            pos_reg  <= '0;
            one_reg  <= '0;
            two_reg  <= '0;
        end else begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            one_reg  <= one_next;
            two_reg  <= two_next;
        end
    end

    // Classify the incoming byte
    always_comb begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        one_next    = one_reg;
        two_next    = two_reg;
        cmd_valid   = 1'b0;
        cmd.op      = sflp_pkg::CMD_STORE;
        cmd.byte_a  = one_reg;
        cmd.byte_b  = two_reg;
        cmd.byte_c  = s_rx_byte;
        cmd_addr    = pos_reg;
        if (accept) begin
            case (mode_reg)
                sflp_pkg::MODE_SHOT: begin
                    if (pos_reg == AW'(1)) begin
                        if (s_rx_byte == 8'd0) begin
                            one_next = s_rx_byte;
                            pos_next = AW'(2);
                        end else begin
                            mode_next = sflp_pkg::MODE_TEXT;
                            pos_next  = '0;
                        end
                    end else if (pos_reg == AW'(2)) begin
                        if (s_rx_byte < sflp_pkg::SHOT_LIMIT) begin
                            two_next = s_rx_byte;
                            pos_next = AW'(3);
                        end else begin
                            mode_next = sflp_pkg::MODE_TEXT;
                            pos_next  = '0;
                        end
                    end else begin
                        cmd_valid = 1'b1;
                        cmd.op    = sflp_pkg::CMD_SHOT;
                        mode_next = sflp_pkg::MODE_TEXT;
                        pos_next  = '0;
                    end
                end
                sflp_pkg::MODE_MSG: begin
                    if (pos_reg == AW'(1)) begin
                        one_next = s_rx_byte;
                        pos_next = AW'(2);
                    end else if (pos_reg == AW'(2)) begin
                        two_next = s_rx_byte;
                        pos_next = AW'(3);
                    end else begin
                        cmd_valid = 1'b1;
                        cmd.op    = sflp_pkg::CMD_MSG;
                        mode_next = sflp_pkg::MODE_TEXT;
                        pos_next  = '0;
                    end
                end
                default: begin
                    // text mode: headers open a frame and drop the partial line
                    if (s_rx_byte == sflp_pkg::HDR_SHOT) begin
                        mode_next = sflp_pkg::MODE_SHOT;
                        pos_next  = AW'(1);
                    end else if (s_rx_byte == sflp_pkg::HDR_MSG) begin
                        mode_next = sflp_pkg::MODE_MSG;
                        pos_next  = AW'(1);
                    end else if (pos_reg >= AW'(LINE_BUFFER_DEPTH - 1)) begin
                        // overflow: drop the line silently
                        pos_next = '0;
                    end else if (s_rx_byte == sflp_pkg::CHAR_CR) begin
                        cmd_valid = 1'b1;
                        cmd.op    = sflp_pkg::CMD_LINE_END;
                        pos_next  = '0;
                    end else begin
                        cmd_valid = 1'b1;
                        cmd.op    = sflp_pkg::CMD_STORE;
                        pos_next  = pos_reg + AW'(1);
                    end
                end
            endcase
        end
    end

endmodule

// ----- design/sflp_queue.sv -----
// ----------------------------------------------------------------------------
// sflp_queue: small command FIFO
// Register-based queue that decouples the classifier from the back end.
// ----------------------------------------------------------------------------
module sflp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/sflp_back.sv -----
// ----------------------------------------------------------------------------
// sflp_back: command executor
// Holds the line store, decodes shot and message commands and plays completed
// lines out byte by byte through the output register.
// ----------------------------------------------------------------------------
module sflp_back #(
    parameter int LINE_BUFFER_DEPTH = 64,
    parameter int AW                = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_empty,
    input  sflp_pkg::cmd_t       cmd,
    input  logic [AW-1:0]        cmd_addr,
    output logic                 cmd_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sflp_pkg::result_t    res
);

    logic [7:0]              line_mem [LINE_BUFFER_DEPTH];
    logic [7:0]              rd_data_reg;
    sflp_pkg::back_state_t   state_reg, state_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [AW-1:0]           end_reg, end_next;
    logic                    valid_reg, valid_next;
    sflp_pkg::result_t       res_reg, res_next;
    logic                    wr_en;
    logic                    out_free;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign res      = res_reg;

    // Line store: write from commands, registered read at the sweep index
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[cmd_addr] <= cmd.byte_c;
        end
        rd_data_reg <= line_mem[idx_reg];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sflp_pkg::BK_IDLE;
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            end_reg   <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            end_reg   <= end_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    // Command execution and line playout
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        end_next   = end_reg;
        valid_next = valid_reg && !m_ready;
        res_next   = res_reg;
        cmd_pop    = 1'b0;
        wr_en      = 1'b0;
        case (state_reg)
            sflp_pkg::BK_IDLE: begin
                if (!cmd_empty) begin
                    case (cmd.op)
                        sflp_pkg::CMD_STORE: begin
                            wr_en   = 1'b1;
                            cmd_pop = 1'b1;
                        end
                        sflp_pkg::CMD_LINE_END: begin
                            wr_en      = 1'b1;
                            cmd_pop    = 1'b1;
                            idx_next   = '0;
                            end_next   = cmd_addr;
                            state_next = sflp_pkg::BK_READ;
                        end
                        sflp_pkg::CMD_SHOT: begin
                            if (out_free) begin
                                cmd_pop     = 1'b1;
                                valid_next  = 1'b1;
                                res_next    = '0;
                                res_next.kind        = sflp_pkg::KIND_SHOT;
                                res_next.shot_damage =
                                    sflp_pkg::damage_lookup(cmd.byte_c[3:0]);
                                res_next.shot_team   = cmd.byte_c[5:4];
                                res_next.shot_player = {cmd.byte_b[4:0], cmd.byte_c[7:6]};
                                res_next.last        = 1'b1;
                            end
                        end
                        default: begin
                            if (out_free) begin
                                cmd_pop     = 1'b1;
                                valid_next  = 1'b1;
                                res_next    = '0;
                                res_next.kind            = sflp_pkg::KIND_MSG;
                                res_next.message_id      = cmd.byte_a;
                                res_next.message_param   = cmd.byte_b;
                                res_next.message_control = cmd.byte_c;
                                res_next.last            = 1'b1;
                            end
                        end
                    endcase
                end
            end
            sflp_pkg::BK_READ: begin
                // read data for idx_reg lands in rd_data_reg at this edge
                state_next = sflp_pkg::BK_EMIT;
            end
            sflp_pkg::BK_EMIT: begin
                if (out_free) begin
                    valid_next         = 1'b1;
                    res_next           = '0;
                    res_next.kind      = sflp_pkg::KIND_TEXT;
                    res_next.text_byte = rd_data_reg;
                    res_next.last      = (idx_reg == end_reg);
                    if (idx_reg == end_reg) begin
                        state_next = sflp_pkg::BK_IDLE;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = sflp_pkg::BK_READ;
                    end
                end
            end
            default: begin
                state_next = sflp_pkg::BK_IDLE;
            end
        endcase
    end

endmodule

// ----- design/serial_frame_and_line_parser.sv -----
// ----------------------------------------------------------------------------
// serial_frame_and_line_parser: serial frame and text line sorter
// Sorts received serial bytes into shot frames, message frames and text lines.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one received byte per transfer (s_rx_byte). The m_
//   channel gives result transfers: a decoded shot, a message, or the bytes
//   of a completed text line in arrival order, carriage return included,
//   with m_last high on the final one. Bytes that finish nothing give no
//   transfer.
//   With the back end idle and the queue empty, a shot or message result
//   passes through the queue entry and then the output register before it
//   shows on m_valid. A line plays out byte by byte: each byte is first
//   read from the line store into its read register, then moved to the
//   output register. Each queued store ahead of a command delays it.
//   While a line plays out, the 4-entry command queue keeps taking bytes,
//   and s_ready drops only when that queue is full.
//   A stalled receiver (m_ready low) holds the output register; the back
//   end then stops at its next result and the queue fills behind it.
//   Reset (aresetn low, synchronous) empties the queue and output register
//   and returns to text mode with an empty line. The line store is not
//   cleared; only bytes written since the line began are ever read.
// ----------------------------------------------------------------------------
module serial_frame_and_line_parser #(
    parameter int LINE_BUFFER_DEPTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [6:0] m_shot_damage,
    output logic [1:0] m_shot_team,
    output logic [6:0] m_shot_player,
    output logic [7:0] m_message_id,
    output logic [7:0] m_message_param,
    output logic [7:0] m_message_control,
    output logic [7:0] m_text_byte,
    output logic       m_last
);

    localparam int AW     = $clog2(LINE_BUFFER_DEPTH);
    localparam int QWIDTH = AW + sflp_pkg::CmdWidth;

    logic                 push_valid;
    sflp_pkg::cmd_t       push_cmd;
    logic [AW-1:0]        push_addr;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;
    logic [QWIDTH-1:0]    q_data;
    sflp_pkg::cmd_t       pop_cmd;
    logic [AW-1:0]        pop_addr;
    sflp_pkg::result_t    res;

    // Byte classifier
    sflp_front #(
        .LINE_BUFFER_DEPTH(LINE_BUFFER_DEPTH),
        .AW(AW)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_rx_byte(s_rx_byte),
        .cmd_valid(push_valid),
        .cmd(push_cmd),
        .cmd_addr(push_addr),
        .cmd_ready(!q_full)
    );

    // Command queue
    sflp_queue #(
        .WIDTH(QWIDTH),
        .DEPTH(4)
    ) u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(push_valid),
        .push_data({push_addr, push_cmd}),
        .full(q_full),
        .pop(q_pop),
        .pop_data(q_data),
        .empty(q_empty)
    );

    assign pop_addr = q_data[QWIDTH-1 -: AW];
    assign pop_cmd  = sflp_pkg::cmd_t'(q_data[sflp_pkg::CmdWidth-1:0]);

    // Executor and output register
    sflp_back #(
        .LINE_BUFFER_DEPTH(LINE_BUFFER_DEPTH),
        .AW(AW)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .cmd_empty(q_empty),
        .cmd(pop_cmd),
        .cmd_addr(pop_addr),
        .cmd_pop(q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .res(res)
    );

    assign m_kind            = res.kind;
    assign m_shot_damage     = res.shot_damage;
    assign m_shot_team       = res.shot_team;
    assign m_shot_player     = res.shot_player;
    assign m_message_id      = res.message_id;
    assign m_message_param   = res.message_param;
    assign m_message_control = res.message_control;
    assign m_text_byte       = res.text_byte;
    assign m_last            = res.last;

endmodule

// ----- design/sflp_checker.sv -----
// ----------------------------------------------------------------------------
// sflp_checker: port-level checks for the serial frame and line parser
// Watches the result channel for reset, stall and result-format rules.
// ----------------------------------------------------------------------------
module sflp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_kind,
    input logic [6:0] m_shot_damage,
    input logic [1:0] m_shot_team,
    input logic [6:0] m_shot_player,
    input logic [7:0] m_text_byte,
    input logic       m_last
);

    // No result right after reset
    a_reset_clears: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_text_byte)
            && $stable(m_last))
        else $error("stalled result changed");

    // Frame results are single transfers
    a_frame_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == sflp_pkg::KIND_SHOT || m_kind == sflp_pkg::KIND_MSG)
            |-> m_last)
        else $error("frame result without last");

    // Non-shot results carry zero shot fields
    a_shot_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != sflp_pkg::KIND_SHOT
            |-> m_shot_damage == 7'd0 && m_shot_team == 2'd0 && m_shot_player == 7'd0)
        else $error("shot fields set on non-shot result");

endmodule

bind serial_frame_and_line_parser sflp_checker u_sflp_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_kind(m_kind),
    .m_shot_damage(m_shot_damage),
    .m_shot_team(m_shot_team),
    .m_shot_player(m_shot_player),
    .m_text_byte(m_text_byte),
    .m_last(m_last)
);

// ----- test/sflp_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sflp_scoreboard: result predictor and scoreboard for the frame and line parser
// Watches both channels, tracks the parser state for every accepted byte,
// queues the results each byte should cause and compares every output
// transfer with the oldest queued result, field by field.
// ----------------------------------------------------------------------------
module sflp_scoreboard #(
    parameter int LINE_DEPTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [1:0] m_kind,
    input  logic [6:0] m_shot_damage,
    input  logic [1:0] m_shot_team,
    input  logic [6:0] m_shot_player,
    input  logic [7:0] m_message_id,
    input  logic [7:0] m_message_param,
    input  logic [7:0] m_message_control,
    input  logic [7:0] m_text_byte,
    input  logic       m_last,
    output int         mismatches,
    output int         awaited,
    output int         bytes_seen,
    output int         shots_seen,
    output int         messages_seen,
    output int         lines_seen,
    output int         aborts_seen,
    output int         overflows_seen
);

    // Damage per low nibble of the shot data byte
    localparam logic [6:0] DAMAGE [16] = '{
        7'd1, 7'd2, 7'd4, 7'd5, 7'd7, 7'd10, 7'd15, 7'd17,
        7'd20, 7'd25, 7'd30, 7'd35, 7'd40, 7'd50, 7'd75, 7'd100
    };

    // Shadow of the parser state
    sflp_pkg::mode_t   frame_mode;
    int                held;
    logic [7:0]        frame_b1;
    logic [7:0]        frame_b2;
    logic [7:0]        line_buf [LINE_DEPTH];

    sflp_pkg::result_t expected_q [$];

    task automatic report(input string what);
        $display("%0t ns  mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic field_check(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Work out what one accepted byte causes and queue it
    task automatic predict_byte(input logic [7:0] b);
        sflp_pkg::result_t r;
        r = '0;
        bytes_seen++;
        if (frame_mode == sflp_pkg::MODE_TEXT &&
            (b == sflp_pkg::HDR_SHOT || b == sflp_pkg::HDR_MSG)) begin
            // header opens a frame, any partial line is abandoned
            frame_mode = (b == sflp_pkg::HDR_SHOT) ? sflp_pkg::MODE_SHOT
                                                   : sflp_pkg::MODE_MSG;
            held = 1;
        end else if (frame_mode == sflp_pkg::MODE_SHOT) begin
            if (held == 1) begin
                if (b == 8'h00) begin
                    frame_b1 = b;
                    held = 2;
                end else begin
                    frame_mode = sflp_pkg::MODE_TEXT;
                    held = 0;
                    aborts_seen++;
                end
            end else if (held == 2) begin
                if (b < sflp_pkg::SHOT_LIMIT) begin
                    frame_b2 = b;
                    held = 3;
                end else begin
                    frame_mode = sflp_pkg::MODE_TEXT;
                    held = 0;
                    aborts_seen++;
                end
            end else begin
                r.kind        = sflp_pkg::KIND_SHOT;
                r.shot_damage = DAMAGE[b[3:0]];
                r.shot_team   = b[5:4];
                r.shot_player = {frame_b2[4:0], b[7:6]};
                r.last        = 1'b1;
                expected_q.push_back(r);
                shots_seen++;
                frame_mode = sflp_pkg::MODE_TEXT;
                held = 0;
            end
        end else if (frame_mode == sflp_pkg::MODE_MSG) begin
            if (held == 1) begin
                frame_b1 = b;
                held = 2;
            end else if (held == 2) begin
                frame_b2 = b;
                held = 3;
            end else begin
                r.kind            = sflp_pkg::KIND_MSG;
                r.message_id      = frame_b1;
                r.message_param   = frame_b2;
                r.message_control = b;
                r.last            = 1'b1;
                expected_q.push_back(r);
                messages_seen++;
                frame_mode = sflp_pkg::MODE_TEXT;
                held = 0;
            end
        end else if (held >= LINE_DEPTH - 1) begin
            // full buffer: byte and line both dropped
            held = 0;
            overflows_seen++;
        end else begin
            line_buf[held] = b;
            held++;
            if (b == sflp_pkg::CHAR_CR) begin
                for (int i = 0; i < held; i++) begin
                    r = '0;
                    r.kind      = sflp_pkg::KIND_TEXT;
                    r.text_byte = line_buf[i];
                    r.last      = (i == held - 1);
                    expected_q.push_back(r);
                end
                lines_seen++;
                held = 0;
            end
        end
    endtask

    // Compare one output transfer with the oldest expectation
    task automatic check_result(input sflp_pkg::result_t got);
        sflp_pkg::result_t want;
        if (expected_q.size() == 0) begin
            report($sformatf("unexpected transfer, kind %0d", got.kind));
        end else begin
            want = expected_q.pop_front();
            field_check("kind", 8'(got.kind), 8'(want.kind));
            field_check("shot_damage", 8'(got.shot_damage), 8'(want.shot_damage));
            field_check("shot_team", 8'(got.shot_team), 8'(want.shot_team));
            field_check("shot_player", 8'(got.shot_player), 8'(want.shot_player));
            field_check("message_id", got.message_id, want.message_id);
            field_check("message_param", got.message_param, want.message_param);
            field_check("message_control", got.message_control,
                        want.message_control);
            field_check("text_byte", got.text_byte, want.text_byte);
            field_check("last", 8'(got.last), 8'(want.last));
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            frame_mode     = sflp_pkg::MODE_TEXT;
            held           = 0;
            frame_b1       = '0;
            frame_b2       = '0;
            mismatches     = 0;
            bytes_seen     = 0;
            shots_seen     = 0;
            messages_seen  = 0;
            lines_seen     = 0;
            aborts_seen    = 0;
            overflows_seen = 0;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready)
                check_result({m_kind, m_shot_damage, m_shot_team, m_shot_player,
                              m_message_id, m_message_param, m_message_control,
                              m_text_byte, m_last});
            if (s_valid && s_ready)
                predict_byte(s_rx_byte);
        end
        awaited = expected_q.size();
    end

endmodule

// ----- test/serial_frame_and_line_parser_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_frame_and_line_parser_test: regression for the frame and line parser
// Feeds a directed opening of shot, message and text traffic, then random
// frames, lines, broken frames and noise with random gaps on both channels.
// The scoreboard predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module serial_frame_and_line_parser_test;

    localparam int LINE_DEPTH   = 64;
    localparam int RANDOM_BYTES = 144;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 40;

    // Opening traffic: shot extremes, aborted shots, headers as frame data,
    // zero byte in a line, header in the middle of a line
    localparam logic [7:0] OPENING [26] = '{
        sflp_pkg::HDR_SHOT, 8'h00, 8'h3F, 8'hFF,
        sflp_pkg::HDR_SHOT, 8'h00, 8'h00, 8'h00,
        sflp_pkg::HDR_SHOT, 8'h01,
        sflp_pkg::HDR_SHOT, 8'h00, 8'h40,
        sflp_pkg::HDR_MSG, sflp_pkg::HDR_SHOT, sflp_pkg::HDR_MSG, sflp_pkg::CHAR_CR,
        8'h41, 8'h00, 8'hFF, sflp_pkg::CHAR_CR,
        8'h61, sflp_pkg::HDR_MSG, 8'h01, 8'h02, 8'h03
    };

    logic       aclk;
    logic       aresetn           = 1'b0;
    logic       s_valid           = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte         = '0;
    logic       m_valid;
    logic       m_ready           = 1'b0;
    logic [1:0] m_kind;
    logic [6:0] m_shot_damage;
    logic [1:0] m_shot_team;
    logic [6:0] m_shot_player;
    logic [7:0] m_message_id;
    logic [7:0] m_message_param;
    logic [7:0] m_message_control;
    logic [7:0] m_text_byte;
    logic       m_last;

    logic       steady            = 1'b0;
    int         fed               = 0;
    int         mismatches, awaited, bytes_seen, shots_seen, messages_seen;
    int         lines_seen, aborts_seen, overflows_seen;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    serial_frame_and_line_parser #(
        .LINE_BUFFER_DEPTH(LINE_DEPTH)
    ) dut (.*);

    sflp_scoreboard #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_scoreboard (.*);

    // Receiver side: random stalls except in the steady stretch
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 12);
    end

    // Watchdog on cycles without any transfer
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, awaited);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Drive one byte from a falling edge, return at the falling edge after
    // its transfer
    task automatic put_byte(input logic [7:0] b);
        int gap;
        steady = (fed >= 60 && fed < 140);
        gap = 0;
        while (!steady && $urandom_range(0, 99) < 12)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        fed++;
    endtask

    // Any byte that neither opens a frame nor ends a line
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == sflp_pkg::HDR_SHOT || c == sflp_pkg::HDR_MSG ||
               c == sflp_pkg::CHAR_CR);
        return c;
    endfunction

    task automatic put_line(input int len);
        repeat (len) put_byte(text_char());
        put_byte(sflp_pkg::CHAR_CR);
    endtask

    // Well-formed shot or message frame with random content
    task automatic put_frame(input bit is_shot);
        if (is_shot) begin
            put_byte(sflp_pkg::HDR_SHOT);
            put_byte(8'h00);
            put_byte(8'($urandom_range(0, 63)));
        end else begin
            put_byte(sflp_pkg::HDR_MSG);
            put_byte(8'($urandom_range(0, 255)));
            put_byte(8'($urandom_range(0, 255)));
        end
        put_byte(8'($urandom_range(0, 255)));
    endtask

    // Four carriage returns bring any open frame or line back to an empty line
    task automatic put_resync();
        repeat (4) put_byte(sflp_pkg::CHAR_CR);
    endtask

    // Stimulus and verdict
    initial begin
        int  pick;
        bit  max_line_done;
        max_line_done = 1'b0;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (OPENING[i]) put_byte(OPENING[i]);

        while (fed < $size(OPENING) + RANDOM_BYTES) begin
            if (!max_line_done && fed >= 30) begin
                // longest line the buffer holds
                put_resync();
                put_line(LINE_DEPTH - 2);
                // one byte past a full buffer drops the line
                repeat (LINE_DEPTH) put_byte(text_char());
                put_line(3);
                max_line_done = 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    put_frame(1'b1);
                end else if (pick < 45) begin
                    put_frame(1'b0);
                end else if (pick < 70) begin
                    put_line($urandom_range(0, 10));
                end else if (pick < 80) begin
                    // aborted shot: bad second or bad third byte
                    put_byte(sflp_pkg::HDR_SHOT);
                    if ($urandom_range(0, 1)) begin
                        put_byte(8'($urandom_range(1, 255)));
                    end else begin
                        put_byte(8'h00);
                        put_byte(8'($urandom_range(64, 255)));
                    end
                end else if (pick < 90) begin
                    // partial line cut off by a frame header
                    repeat ($urandom_range(1, 5)) put_byte(text_char());
                    put_frame(1'($urandom_range(0, 1)));
                end else begin
                    put_byte(8'($urandom_range(0, 255)));
                end
            end
        end
        s_valid <= 1'b0;
        steady  = 1'b0;

        while (awaited != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d bytes: %0d shots, %0d messages, %0d text lines",
                 bytes_seen, shots_seen, messages_seen, lines_seen);
        $display("with %0d aborted shot frames and %0d overflowed lines, %0d mismatches",
                 aborts_seen, overflows_seen, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
